### design/rxmh_pkg.sv
// Package for the rotate-XOR mixing hash: lane constants, rotation amounts,
// pipeline token types and the rotate helper. Depends on nothing.

package rxmh_pkg;

    localparam int unsigned NUM_LANES = 8;
    localparam int unsigned LANE_W    = 32;

    typedef logic [NUM_LANES-1:0][LANE_W-1:0] t_lanes;

    // Initial lane values, lane 0 in the lowest slot.
    localparam t_lanes INIT_LANE = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    // Left rotation per lane, lane 0 in the lowest slot.
    localparam logic [NUM_LANES-1:0][4:0] ROT_AMT = {
        5'd29, 5'd23, 5'd19, 5'd17, 5'd13, 5'd11, 5'd7, 5'd5
    };

    // Per-byte index weights for lanes 0 and 1.
    localparam logic [LANE_W-1:0] MUL_LANE0 = 32'h01000193;
    localparam logic [LANE_W-1:0] MUL_LANE1 = 32'h1000061A;

    // Registered input word.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       present;
        logic       eom;
    } t_in;

    // Token passed between lane stages. a and b are the two most recently
    // updated lanes of this byte; dig collects the final lanes on an end word.
    typedef struct packed {
        logic              valid;
        logic              present;
        logic              eom;
        logic [LANE_W-1:0] a;
        logic [LANE_W-1:0] b;
        t_lanes            dig;
    } t_tok;

    // Rotate left by a nonzero amount.
    function automatic logic [LANE_W-1:0] f_rotl(input logic [LANE_W-1:0] v,
                                                 input logic [4:0] r);
        return (v << r) | (v >> (6'd32 - {1'b0, r}));
    endfunction

endpackage

### design/rxmh_out_buf.sv
// Digest serializer: holds one finished 256-bit digest and hands it out as
// eight 32-bit words, lane 0 first. Depends on rxmh_pkg.

module rxmh_out_buf import rxmh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_lanes      i_digest,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_lanes     r_words;
    logic [2:0] r_cnt;
    logic       r_valid;
    logic       s_take;
    logic       s_last;

    assign s_last = (r_cnt == 3'd7);
    assign s_take = r_valid & ~i_stall;
    // A new digest may enter when empty or when the final word leaves now.
    assign o_free = ~r_valid | (s_take & s_last);

    assign o_valid       = r_valid;
    assign o_digest_word = r_words[0];
    assign o_word_index  = r_cnt;
    assign o_last_word   = s_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= 3'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_cnt   <= 3'd0;
            r_words <= i_digest;
        end else if (s_take) begin
            r_words <= t_lanes'(r_words >> LANE_W);
            r_cnt   <= r_cnt + 3'd1;
            if (s_last) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

### design/rotate_xor_mix_hash256.sv
// Byte-serial 256-bit rotate-XOR mixing hash, top level.
// A word that ends a message passes the input register and the token registers;
// its digest is then loaded into the output buffer, which hands it out by word.
// Throughput: one input word per cycle unless the pipeline stalls; a message end
// holds the output port for eight words. Reset (synchronous, active low) loads the
// initial lanes, clears the byte weights and empties the pipeline and output buffer.

module rotate_xor_mix_hash256 import rxmh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    // The lane update is a chain: lane k of a byte needs the new lanes k-1
    // and k-2 of the same byte. The chain is skewed over a pipeline so that
    // each stage holds one 32-bit add. Lanes 0 and 1 are updated from the
    // input register; lane k (k >= 2) is updated one stage later than lane
    // k-1. A token travels with each word and carries the two newest lane
    // values of its byte, plus the finished lanes of an ending message.
    // Since every lane sees the words in the same order, the result matches
    // the fully serial update.

    t_in                     r_in;
    t_tok                    r_tok [1:6];
    t_tok                    n_tok [1:7];
    t_lanes                  r_lane;
    t_lanes                  n_new;
    logic [LANE_W-1:0]       r_acc0;
    logic [LANE_W-1:0]       r_acc1;
    logic [NUM_LANES-1:0]    s_val;
    logic [NUM_LANES-1:0]    s_pres;
    logic [NUM_LANES-1:0]    s_eom;
    logic                    s_adv;
    logic                    s_load;
    logic                    s_free;

    // The whole pipeline moves together. It holds only when the last stage
    // has a finished digest and the output buffer cannot take it.
    assign s_load  = r_tok[6].valid & r_tok[6].eom & s_free;
    assign s_adv   = ~(r_tok[6].valid & r_tok[6].eom) | s_free;
    assign o_stall = ~s_adv;

    always_comb begin
        // Lanes 0 and 1 take the byte and the index weight. The weights are
        // kept as running sums, so no multiplier is needed.
        n_new[0] = f_rotl(r_lane[0], ROT_AMT[0]) ^ {24'd0, r_in.data} ^ r_acc0;
        n_new[1] = f_rotl(r_lane[1], ROT_AMT[1]) ^ {24'd0, r_in.data} ^ r_acc1;

        n_tok[1].valid   = r_in.valid;
        n_tok[1].present = r_in.present;
        n_tok[1].eom     = r_in.eom;
        n_tok[1].a       = n_new[0];
        n_tok[1].b       = n_new[1];
        n_tok[1].dig     = '0;
        n_tok[1].dig[0]  = r_in.present ? n_new[0] : r_lane[0];
        n_tok[1].dig[1]  = r_in.present ? n_new[1] : r_lane[1];

        s_val[0]  = r_in.valid;
        s_pres[0] = r_in.present;
        s_eom[0]  = r_in.eom;
        s_val[1]  = r_in.valid;
        s_pres[1] = r_in.present;
        s_eom[1]  = r_in.eom;

        // Lanes 2 to 7 each add the two lanes updated just before them.
        for (int k = 2; k < NUM_LANES; k++) begin
            n_new[k] = f_rotl(r_lane[k], ROT_AMT[k]) ^ (r_tok[k-1].a + r_tok[k-1].b);

            n_tok[k]        = r_tok[k-1];
            n_tok[k].a      = r_tok[k-1].b;
            n_tok[k].b      = n_new[k];
            n_tok[k].dig[k] = r_tok[k-1].present ? n_new[k] : r_lane[k];

            s_val[k]  = r_tok[k-1].valid;
            s_pres[k] = r_tok[k-1].present;
            s_eom[k]  = r_tok[k-1].eom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
            for (int k = 1; k <= 6; k++) begin
                r_tok[k].valid <= 1'b0;
            end
            r_lane <= INIT_LANE;
            r_acc0 <= '0;
            r_acc1 <= '0;
        end else if (s_adv) begin
            r_in.valid   <= i_valid;
            r_in.data    <= i_data_byte;
            r_in.present <= i_byte_present;
            r_in.eom     <= i_end_of_message;

            for (int k = 1; k <= 6; k++) begin
                r_tok[k] <= n_tok[k];
            end

            // Each lane restarts on an ending word, takes its update on a present byte, else holds.
            for (int k = 0; k < NUM_LANES; k++) begin
                if (s_val[k] && s_eom[k]) begin
                    r_lane[k] <= INIT_LANE[k];
                end else if (s_val[k] && s_pres[k]) begin
                    r_lane[k] <= n_new[k];
                end
            end

            // Index weights: index times the lane constant, reset per message.
            if (r_in.valid) begin
                if (r_in.eom) begin
                    r_acc0 <= '0;
                    r_acc1 <= '0;
                end else if (r_in.present) begin
                    r_acc0 <= r_acc0 + MUL_LANE0;
                    r_acc1 <= r_acc1 + MUL_LANE1;
                end
            end
        end
    end

    // The last stage completes lane 7 and hands the full digest over.
    rxmh_out_buf u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (s_load),
        .i_digest      (n_tok[7].dig),
        .o_free        (s_free),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

### tb/rotate_xor_mix_hash256_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the rotate-XOR mixing hash: a queue-fed word driver,
// a digest monitor and a built-in predictor of the eight hash lanes.
// Depends only on the rotate_xor_mix_hash256 top level.

module rotate_xor_mix_hash256_tb;

    // Run limits. The slowest correct run is roughly 240 words with their sender gaps,
    // plus no more digests than words, each 8 words with receiver stalls, and
    // one long receiver hold, so the cycle limit below leaves a wide margin.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    // Starting lane values and per-lane rotations, lane 0 in the lowest slot.
    localparam logic [7:0][31:0] SEED_LANE = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };
    localparam logic [7:0][4:0] LANE_ROT = {
        5'd29, 5'd23, 5'd19, 5'd17, 5'd13, 5'd11, 5'd7, 5'd5
    };
    localparam logic [31:0] IDX_MUL0 = 32'h01000193;
    localparam logic [31:0] IDX_MUL1 = 32'h1000061A;

    // One planned input word plus its sender gap and the pressure markers:
    // drain holds the word back until every digest has come out, hold makes
    // the receiver stall for a long stretch once the word is offered.
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eom;
        logic [3:0] gap;
        logic       drain;
        logic       hold;
    } t_plan_item;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic [7:0]  i_data_byte      = 8'd0;
    logic        i_byte_present   = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        i_stall          = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    rotate_xor_mix_hash256 dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Words waiting to be offered, and digest words the predictor has produced
    // but the block has not yet delivered.
    t_plan_item word_plan[$];
    t_digest    digest_due[$];

    // Predictor state: the eight lanes and the running byte index.
    logic [7:0][31:0] lane_st;
    logic [31:0]      byte_ctr;

    // Bookkeeping. due_now is private to the driver; sent_cnt, rx_cnt and due_total,
    // which other processes read, are updated with nonblocking assignments so that
    // their readers always see the value from before the clock edge.
    t_plan_item cur_word;
    int         gap_cnt     = 0;
    int         due_now     = 0;
    int         due_total   = 0;
    int         sent_cnt    = 0;
    int         rx_cnt      = 0;
    int         rx_wait     = 0;
    int         hold_left   = 0;
    int         errors      = 0;
    int         plan_total  = 0;
    logic       hold_go     = 1'b0;
    logic       hold_next;
    logic [31:0] cycle_cnt  = 32'd0;
    t_digest    want;

    function automatic logic [31:0] rol32(input logic [31:0] v, input logic [4:0] r);
        return (v << r) | (v >> (32 - int'(r)));
    endfunction

    function automatic void restart_lanes();
        lane_st  = SEED_LANE;
        byte_ctr = 32'd0;
    endfunction

    // Applies one accepted word to the predicted lanes. A present byte is mixed
    // into lanes 0 and 1 together with the weighted byte index, and each later
    // lane folds in the sum of the two lanes updated just before it. An end of
    // message queues all eight lanes as digest words and restarts the hash.
    function automatic void fold_word(input t_plan_item w);
        t_digest d;
        if (w.present) begin
            lane_st[0] = rol32(lane_st[0], LANE_ROT[0]) ^ {24'd0, w.data}
                         ^ (byte_ctr * IDX_MUL0);
            lane_st[1] = rol32(lane_st[1], LANE_ROT[1]) ^ {24'd0, w.data}
                         ^ (byte_ctr * IDX_MUL1);
            for (int k = 2; k < 8; k++) begin
                lane_st[k] = rol32(lane_st[k], LANE_ROT[k])
                             ^ (lane_st[k-2] + lane_st[k-1]);
            end
            byte_ctr = byte_ctr + 32'd1;
        end
        if (w.eom) begin
            for (int k = 0; k < 8; k++) begin
                d.word = lane_st[k];
                d.idx  = 3'(k);
                d.last = (k == 7);
                digest_due.push_back(d);
            end
            due_now = due_now + 8;
            restart_lanes();
        end
    endfunction

    // Driver. A word stays on the port while the block stalls it; otherwise the
    // next planned word goes out once its gap has passed and, for a word that
    // asks for it, once every predicted digest word has been received.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            hold_go <= 1'b0;
            gap_cnt = 0;
            restart_lanes();
        end else begin
            hold_next = 1'b0;
            if (i_valid && !o_stall) begin
                fold_word(cur_word);
                sent_cnt <= sent_cnt + 1;
            end
            if (!(i_valid && o_stall)) begin
                if (word_plan.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (gap_cnt < int'(word_plan[0].gap)
                             || (word_plan[0].drain && due_now != rx_cnt)) begin
                    gap_cnt = gap_cnt + 1;
                    i_valid <= 1'b0;
                end else begin
                    cur_word = word_plan.pop_front();
                    gap_cnt  = 0;
                    i_valid          <= 1'b1;
                    i_data_byte      <= cur_word.data;
                    i_byte_present   <= cur_word.present;
                    i_end_of_message <= cur_word.eom;
                    hold_next = cur_word.hold;
                end
            end
            hold_go   <= hold_next;
            due_total <= due_now;
        end
    end

    // Monitor and receiver. Every delivered digest word is checked against the
    // oldest prediction. After each word the receiver draws a stall of random
    // length, except in quiet stretches where it takes words back to back.
    // A hold request from the driver makes it refuse output for a long stretch
    // so the block backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                rx_cnt <= rx_cnt + 1;
                if (digest_due.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected digest word, expected none, got %h idx %0d last %b",
                             $time, o_digest_word, o_word_index, o_last_word);
                end else begin
                    want = digest_due.pop_front();
                    if (o_digest_word !== want.word) begin
                        errors = errors + 1;
                        $display("%0t: digest_word mismatch, expected %h, got %h",
                                 $time, want.word, o_digest_word);
                    end
                    if (o_word_index !== want.idx) begin
                        errors = errors + 1;
                        $display("%0t: word_index mismatch, expected %0d, got %0d",
                                 $time, want.idx, o_word_index);
                    end
                    if (o_last_word !== want.last) begin
                        errors = errors + 1;
                        $display("%0t: last_word mismatch, expected %b, got %b",
                                 $time, want.last, o_last_word);
                    end
                end
                rx_wait = (cycle_cnt[10:9] == 2'b00) ? 0 : $urandom_range(0, 15);
            end
            if (hold_go) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                i_stall <= 1'b1;
            end else if (rx_wait != 0) begin
                rx_wait = rx_wait - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 32'd1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic plan_word(input logic [7:0] data, input logic present,
                             input logic eom, input int gap_cap,
                             input logic drain, input logic hold);
        t_plan_item w;
        w.data    = data;
        w.present = present;
        w.eom     = eom;
        w.gap     = 4'($urandom_range(0, gap_cap));
        w.drain   = drain;
        w.hold    = hold;
        word_plan.push_back(w);
    endtask

    // Plans one message of len random bytes. The end is either carried by the
    // last byte or sent as a bare end marker afterwards; an empty message is
    // always a bare end marker. The first word carries the pressure markers.
    task automatic plan_message(input int len, input int gap_cap, input logic drain,
                                input logic hold, inout int counted);
        logic bare_end;
        bare_end = (len == 0) || ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++) begin
            plan_word(8'($urandom), 1'b1, (i == len - 1) && !bare_end, gap_cap,
                      drain && (i == 0), hold && (i == 0));
        end
        if (bare_end) begin
            plan_word(8'($urandom), 1'b0, 1'b1, gap_cap, drain && (len == 0),
                      hold && (len == 0));
        end
        counted = counted + len + (bare_end ? 1 : 0);
    endtask

    initial begin
        int   counted;
        int   gap_cap;
        logic did_hold;
        logic did_drain;

        counted   = 0;
        did_hold  = 1'b0;
        did_drain = 1'b0;

        // Directed words. An empty message gives the starting lanes; a word with
        // neither byte nor end must leave no trace; a single byte of all ones
        // ends its own message; data of all zeros and alternating bits run through
        // a message whose last byte carries the end, two bare ends in a row give two
        // more empty digests, and a final message closes with a bare end marker.
        plan_word(8'hFF, 1'b0, 1'b1, 15, 1'b0, 1'b0);
        plan_word(8'h5A, 1'b0, 1'b0, 15, 1'b0, 1'b0);
        plan_word(8'hFF, 1'b1, 1'b1, 15, 1'b0, 1'b0);
        plan_word(8'h00, 1'b1, 1'b0, 15, 1'b0, 1'b0);
        plan_word(8'hAA, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        plan_word(8'hC3, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        plan_word(8'h55, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        plan_word(8'hFF, 1'b1, 1'b1, 0, 1'b0, 1'b0);
        plan_word(8'h00, 1'b0, 1'b1, 15, 1'b0, 1'b0);
        plan_word(8'h33, 1'b0, 1'b1, 0, 1'b0, 1'b0);
        plan_word(8'h01, 1'b1, 1'b0, 15, 1'b0, 1'b0);
        plan_word(8'h80, 1'b1, 1'b0, 15, 1'b0, 1'b0);
        plan_word(8'h7F, 1'b1, 1'b0, 15, 1'b0, 1'b0);
        plan_word(8'hCC, 1'b0, 1'b1, 15, 1'b0, 1'b0);

        // Random messages. Each group of words uses either full random gaps or
        // none at all. Once, a burst of short back-to-back messages follows a
        // long receiver hold so the pipeline and output buffer fill up; once,
        // the sender waits for the block to drain completely.
        while (counted < 150) begin
            gap_cap = ($urandom_range(0, 3) == 0) ? 0 : 15;
            if (!did_hold && counted >= 60) begin
                did_hold = 1'b1;
                for (int m = 0; m < 16; m++) begin
                    plan_message($urandom_range(0, 3), 0, 1'b0, m == 0, counted);
                end
            end else if (!did_drain && counted >= 120) begin
                did_drain = 1'b1;
                plan_message($urandom_range(1, 6), gap_cap, 1'b1, 1'b0, counted);
            end else if ($urandom_range(0, 5) == 0) begin
                plan_word(8'($urandom), 1'b0, 1'b0, gap_cap, 1'b0, 1'b0);
            end else begin
                plan_message($urandom_range(0, 12), gap_cap, 1'b0, 1'b0, counted);
            end
        end

        // A longer message so that the lane 1 index product wraps around 32 bits.
        plan_message(48, 2, 1'b0, 1'b0, counted);

        plan_total = word_plan.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_cnt != plan_total) @(posedge i_clk);
        while (rx_cnt != due_total) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
design/rxmh_pkg.sv
design/rxmh_out_buf.sv
design/rotate_xor_mix_hash256.sv
tb/rotate_xor_mix_hash256_tb.sv
